// ----- rtl/core/eos_pkg.sv -----
// Shared types, field widths, register codes and reset values of the envelope onset slicer.
package eos_pkg;

   // Field widths of the stream and register payloads.
   localparam int SAMPLE_W = 24;
   localparam int COEFF_W  = 16;
   localparam int GUARD_W  = 16;
   localparam int THRESH_W = 24;
   localparam int CHAN_W   = 2;
   localparam int START_W  = 24;
   localparam int END_W    = 25;
   localparam int TOTAL_W  = 25;

   // Stream bus widths, padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Defaults for the top-level parameters and fixed build choices.
   localparam int INDEX_BITS_DEFAULT = 24;
   localparam int MAX_CHANNELS       = 2;
   localparam int QUEUE_DEPTH        = 4;
   localparam int RESULT_DEPTH       = 4;

   // Reset values of the configuration registers.
   localparam logic [COEFF_W-1:0]  ATTACK_RESET    = 16'd64067;
   localparam logic [COEFF_W-1:0]  RELEASE_RESET   = 16'd65517;
   localparam logic [GUARD_W-1:0]  GUARD_RESET     = 16'd1764;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 24'd838861;
   localparam logic [CHAN_W-1:0]   CHANNELS_RESET  = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK    = 3'd0,
      CSR_RELEASE   = 3'd1,
      CSR_GUARD     = 3'd2,
      CSR_THRESHOLD = 3'd3,
      CSR_CHANNELS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COEFF_W-1:0]  attack_coeff;
      logic [COEFF_W-1:0]  release_coeff;
      logic [GUARD_W-1:0]  guard_length;
      logic [THRESH_W-1:0] onset_threshold;
      logic [CHAN_W-1:0]   channel_count;
   } cfg_type;

   // One classified frame: the averaged magnitude and the end-of-buffer mark.
   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic                final_frame;
   } item_type;

   typedef struct packed {
      logic [START_W-1:0] slice_start;
      logic [END_W-1:0]   slice_end;
      logic               slice_valid;
      logic               last_result;
      logic [TOTAL_W-1:0] total_slices;
   } result_type;

endpackage

// ----- rtl/core/eos_front.sv -----
// Front end: takes the magnitudes of a frame's samples and averages them by channel count.
module eos_front (
   input  logic signed [eos_pkg::SAMPLE_W-1:0] left_sample,
   input  logic signed [eos_pkg::SAMPLE_W-1:0] right_sample,
   input  logic                                final_frame,
   input  logic [eos_pkg::CHAN_W-1:0]          channel_count,
   output eos_pkg::item_type                   item
);

   logic [eos_pkg::SAMPLE_W-1:0] left_mag;
   logic [eos_pkg::SAMPLE_W-1:0] right_mag;
   logic [eos_pkg::SAMPLE_W:0]   mag_sum;
   logic                         stereo;

   // Two's complement negation; the most negative sample maps to 2^23, which still fits.
   assign left_mag  = left_sample[eos_pkg::SAMPLE_W-1]  ? (~left_sample + 1'b1)  : left_sample;
   assign right_mag = right_sample[eos_pkg::SAMPLE_W-1] ? (~right_sample + 1'b1) : right_sample;

   // Zero acts as one channel; anything above two is clamped to the build limit.
   assign stereo  = (channel_count >= 2'd2) && (eos_pkg::MAX_CHANNELS >= 2);
   assign mag_sum = {1'b0, left_mag} + {1'b0, right_mag};

   always_comb begin
      item.final_frame = final_frame;
      if (stereo) begin
         item.level = mag_sum[eos_pkg::SAMPLE_W:1];
      end else begin
         item.level = left_mag;
      end
   end

endmodule

// ----- rtl/core/eos_queue.sv -----
// Short register queue that decouples the front end from the envelope back end.
module eos_queue #(
   parameter int DEPTH = eos_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  eos_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_ready,
   output eos_pkg::item_type rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   eos_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/core/eos_back.sv -----
// Back end: envelope follower, onset detection, slice bookkeeping and the result buffer.
module eos_back #(
   parameter int INDEX_BITS = eos_pkg::INDEX_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  eos_pkg::cfg_type   cfg,
   input  logic               item_valid,
   output logic               item_ready,
   input  eos_pkg::item_type  item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eos_pkg::result_type rsp
);

   // Wide enough for any frame index plus one.
   localparam int WIDE_W = 33;
   localparam int RB_PTR_W = $clog2(eos_pkg::RESULT_DEPTH);
   localparam int RB_CNT_W = $clog2(eos_pkg::RESULT_DEPTH + 1);
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   // Slicer state.
   logic [eos_pkg::SAMPLE_W-1:0] env_ff, env_in;
   logic                         prev_above_ff, prev_above_in;
   logic [eos_pkg::GUARD_W-1:0]  guard_ff, guard_in;
   logic [INDEX_BITS-1:0]        index_ff, index_in;
   logic [eos_pkg::START_W-1:0]  open_start_ff, open_start_in;
   logic                         open_ff, open_in;
   logic [eos_pkg::TOTAL_W-1:0]  total_ff, total_in;

   // Result buffer.
   eos_pkg::result_type rb_mem_ff [eos_pkg::RESULT_DEPTH];
   logic [RB_PTR_W-1:0] rb_wr_ptr_ff, rb_wr_ptr_in;
   logic [RB_PTR_W-1:0] rb_rd_ptr_ff, rb_rd_ptr_in;
   logic [RB_CNT_W-1:0] rb_count_ff, rb_count_in;
   logic [RB_PTR_W-1:0] rb_wr_ptr_next;

   logic                         pop;
   logic                         drain;
   logic                         rising;
   logic [eos_pkg::SAMPLE_W-1:0] diff;
   logic [eos_pkg::COEFF_W:0]    mul_a;
   logic [eos_pkg::SAMPLE_W-1:0] mul_b;
   logic [40:0]                  product;
   logic [40:0]                  rounded;
   logic [eos_pkg::SAMPLE_W:0]   env_sum;
   logic [eos_pkg::SAMPLE_W-1:0] env_new;
   logic                         above;
   logic [WIDE_W-1:0]            index_wide;
   logic [WIDE_W-1:0]            index_plus;

   eos_pkg::result_type onset_res, close_res, wr0_res;
   logic                onset_v, close_v, wr0_en, wr1_en;

   function automatic logic [RB_PTR_W-1:0] ptr_next(input logic [RB_PTR_W-1:0] p);
      ptr_next = (p == RB_PTR_W'(eos_pkg::RESULT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Take an item only when the buffer can hold the two results it may cause.
   assign item_ready = (rb_count_ff <= RB_CNT_W'(eos_pkg::RESULT_DEPTH - 2));
   assign pop        = item_valid && item_ready;

   // Rising: a*env + (1-a)*avg = env + (1-a)*(avg-env), so one multiplier serves both cases.
   assign rising  = (item.level > env_ff);
   assign diff    = item.level - env_ff;
   assign mul_a   = rising ? (17'h10000 - {1'b0, cfg.attack_coeff}) : {1'b0, cfg.release_coeff};
   assign mul_b   = rising ? diff : env_ff;
   assign product = 41'(mul_a) * 41'(mul_b);
   assign rounded = product + (rising ? 41'h8000 : 41'h0);
   assign env_sum = rising ? ({1'b0, env_ff} + rounded[40:16]) : rounded[40:16];
   assign env_new = env_sum[eos_pkg::SAMPLE_W-1:0];
   assign above   = (env_new > cfg.onset_threshold);

   assign index_wide = WIDE_W'(index_ff);
   assign index_plus = index_wide + 1'b1;

   always_comb begin
      env_in        = env_ff;
      prev_above_in = prev_above_ff;
      guard_in      = guard_ff;
      index_in      = index_ff;
      open_start_in = open_start_ff;
      open_in       = open_ff;
      total_in      = total_ff;
      onset_res     = '0;
      close_res     = '0;
      onset_v       = 1'b0;
      close_v       = 1'b0;
      if (pop) begin
         env_in = env_new;
         if (guard_ff != '0) begin
            guard_in = guard_ff - 1'b1;
         end else if (above && !prev_above_ff) begin
            // A new onset closes the slice that the previous onset opened.
            if (open_ff) begin
               onset_v               = 1'b1;
               onset_res.slice_start = open_start_ff;
               onset_res.slice_end   = index_wide[eos_pkg::END_W-1:0];
               onset_res.slice_valid = 1'b1;
            end
            open_start_in = index_wide[eos_pkg::START_W-1:0];
            open_in       = 1'b1;
            if (total_ff != '1) begin
               total_in = total_ff + 1'b1;
            end
            guard_in = cfg.guard_length;
         end
         prev_above_in = above;
         if (item.final_frame) begin
            close_v                = 1'b1;
            close_res.last_result  = 1'b1;
            close_res.total_slices = total_in;
            if (open_in) begin
               close_res.slice_start = open_start_in;
               close_res.slice_end   = index_plus[eos_pkg::END_W-1:0];
               close_res.slice_valid = 1'b1;
            end
            env_in        = '0;
            prev_above_in = 1'b0;
            guard_in      = '0;
            index_in      = '0;
            open_start_in = '0;
            open_in       = 1'b0;
            total_in      = '0;
         end else if (index_ff != INDEX_MAX) begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   // Onset result goes first; the closing result follows in the next slot.
   assign wr0_en         = onset_v || close_v;
   assign wr1_en         = onset_v && close_v;
   assign wr0_res        = onset_v ? onset_res : close_res;
   assign rb_wr_ptr_next = ptr_next(rb_wr_ptr_ff);
   assign drain          = rsp_valid && rsp_ready;
   assign rsp_valid      = (rb_count_ff != '0);
   assign rsp            = rb_mem_ff[rb_rd_ptr_ff];

   always_comb begin
      rb_wr_ptr_in = rb_wr_ptr_ff;
      if (wr1_en) begin
         rb_wr_ptr_in = ptr_next(rb_wr_ptr_next);
      end else if (wr0_en) begin
         rb_wr_ptr_in = rb_wr_ptr_next;
      end
      rb_rd_ptr_in = drain ? ptr_next(rb_rd_ptr_ff) : rb_rd_ptr_ff;
      rb_count_in  = rb_count_ff + RB_CNT_W'(wr0_en) + RB_CNT_W'(wr1_en) - RB_CNT_W'(drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff        <= '0;
         prev_above_ff <= 1'b0;
         guard_ff      <= '0;
         index_ff      <= '0;
         open_start_ff <= '0;
         open_ff       <= 1'b0;
         total_ff      <= '0;
         rb_wr_ptr_ff  <= '0;
         rb_rd_ptr_ff  <= '0;
         rb_count_ff   <= '0;
      end else begin
         env_ff        <= env_in;
         prev_above_ff <= prev_above_in;
         guard_ff      <= guard_in;
         index_ff      <= index_in;
         open_start_ff <= open_start_in;
         open_ff       <= open_in;
         total_ff      <= total_in;
         rb_wr_ptr_ff  <= rb_wr_ptr_in;
         rb_rd_ptr_ff  <= rb_rd_ptr_in;
         rb_count_ff   <= rb_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         rb_mem_ff[rb_wr_ptr_ff] <= wr0_res;
      end
      if (wr1_en) begin
         rb_mem_ff[rb_wr_ptr_next] <= close_res;
      end
   end

endmodule

// ----- rtl/core/envelope_onset_slicer.sv -----
// Top level of the envelope onset slicer: configuration registers and the front/back split.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_tvalid/tready    tdata = left_sample, right_sample; tlast = final_frame
//   rsp_*     out        rsp_tvalid/tready    tdata = slice_start, slice_end, total_slices;
//                                             tuser = slice_valid; tlast = last_result
//   csr_*     in         csr_we               csr_index selects the register, csr_wdata the value
//
// Flow: one frame is accepted per cycle while the queue has room. The envelope recurrence, one
// multiply-add and the threshold compare are combinational in the back end, so the back end also takes
// one frame per cycle while its four-entry result buffer has room for two results.
// Results leave at one per cycle while rsp_tready is high; a frame that causes both an onset result
// and a closing result therefore occupies two transfers of the result channel.
// An accepted frame is registered in the queue, and its results in the result buffer before they leave.
// Reset is synchronous and active high; it restores the register defaults and clears all state.
// Stalls: the four-entry queue between front and back absorbs short result-side stalls, and
// req_tready falls only when that queue is full.
module envelope_onset_slicer #(
   parameter int INDEX_BITS = eos_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Frame input.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [eos_pkg::REQ_DATA_W-1:0]     req_tdata,   // [23:0] left_sample, [47:24] right_sample
   input  logic                               req_tlast,   // final_frame
   // Slice results.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [eos_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [23:0] slice_start, [48:24] slice_end,
                                                           // [73:49] total_slices, [79:74] zero
   output logic                               rsp_tuser,   // slice_valid
   output logic                               rsp_tlast,   // last_result
   // Register writes.
   input  logic                               csr_we,
   input  logic [eos_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [eos_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   eos_pkg::cfg_type    cfg_ff, cfg_in;
   eos_pkg::item_type   front_item;
   eos_pkg::item_type   queue_item;
   eos_pkg::result_type result;
   logic                queue_valid;
   logic                queue_ready;

   // Register file. Writes to unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (eos_pkg::csr_index_type'(csr_index))
            eos_pkg::CSR_ATTACK: begin
               cfg_in.attack_coeff = csr_wdata[eos_pkg::COEFF_W-1:0];
            end
            eos_pkg::CSR_RELEASE: begin
               cfg_in.release_coeff = csr_wdata[eos_pkg::COEFF_W-1:0];
            end
            eos_pkg::CSR_GUARD: begin
               cfg_in.guard_length = csr_wdata[eos_pkg::GUARD_W-1:0];
            end
            eos_pkg::CSR_THRESHOLD: begin
               cfg_in.onset_threshold = csr_wdata[eos_pkg::THRESH_W-1:0];
            end
            eos_pkg::CSR_CHANNELS: begin
               cfg_in.channel_count = csr_wdata[eos_pkg::CHAN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff    <= eos_pkg::ATTACK_RESET;
         cfg_ff.release_coeff   <= eos_pkg::RELEASE_RESET;
         cfg_ff.guard_length    <= eos_pkg::GUARD_RESET;
         cfg_ff.onset_threshold <= eos_pkg::THRESHOLD_RESET;
         cfg_ff.channel_count   <= eos_pkg::CHANNELS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end reduces each frame to one averaged magnitude before it is queued.
   eos_front u_front (
      .left_sample   (req_tdata[23:0]),
      .right_sample  (req_tdata[47:24]),
      .final_frame   (req_tlast),
      .channel_count (cfg_ff.channel_count),
      .item          (front_item)
   );

   eos_queue #(
      .DEPTH (eos_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_item  (front_item),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_item  (queue_item)
   );

   // The back end owns the envelope and slice state and buffers results for the output.
   eos_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (result)
   );

   assign rsp_tdata = {6'd0, result.total_slices, result.slice_end, result.slice_start};
   assign rsp_tuser = result.slice_valid;
   assign rsp_tlast = result.last_result;

endmodule

// ----- rtl/core/eos_checker.sv -----
// Port-level checks on the slicer's result stream, bound to the top level.
module eos_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [eos_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only a closing result may describe no slice.
   a_onset_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("onset result without a valid slice");

   // A result without a slice carries zero bounds.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[48:0] == 49'd0))
      else $error("empty slice with nonzero bounds");

   // The slice total is reported only on the closing result.
   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[73:49] == 25'd0))
      else $error("slice total outside the closing result");

   // Reset empties the result buffer.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind envelope_onset_slicer eos_port_checker u_eos_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- sim/eos_checker.sv -----
`timescale 1ns / 100ps
// Checker for the envelope onset slicer: predicts slice results per frame and compares them.
module eos_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [eos_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [eos_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [eos_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [eos_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              pending_results
);
   import eos_pkg::*;

   cfg_type               settings;
   logic [SAMPLE_W-1:0]   envelope;
   logic                  was_above;
   logic [GUARD_W-1:0]    guard_left;
   logic [START_W-1:0]    frame_count;
   logic [START_W-1:0]    open_start;
   logic                  slice_is_open;
   logic [TOTAL_W-1:0]    slices_seen;
   result_type            expected_slices[$];

   task automatic report_failure(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [SAMPLE_W-1:0] sample_magnitude(input logic [SAMPLE_W-1:0] s);
      // The most negative sample maps to 2^23, which still fits unsigned.
      return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
   endfunction

   task automatic clear_buffer_state();
      envelope      = '0;
      was_above     = 1'b0;
      guard_left    = '0;
      frame_count   = '0;
      open_start    = '0;
      slice_is_open = 1'b0;
      slices_seen   = '0;
   endtask

   task automatic predict_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                                input logic final_mark);
      logic [SAMPLE_W:0]   mag_sum;
      logic [SAMPLE_W-1:0] level;
      logic [63:0]         blend;
      logic                above;
      result_type          res;
      // Channel counts of 0 and 1 are mono; 2 and 3 both average two channels.
      if (settings.channel_count >= 2) begin
         mag_sum = {1'b0, sample_magnitude(left)} + {1'b0, sample_magnitude(right)};
         level   = mag_sum[SAMPLE_W:1];
      end else begin
         level = sample_magnitude(left);
      end
      if (level > envelope) begin
         blend = 64'(settings.attack_coeff) * 64'(envelope)
               + (64'd65536 - 64'(settings.attack_coeff)) * 64'(level) + 64'd32768;
      end else begin
         blend = 64'(settings.release_coeff) * 64'(envelope);
      end
      envelope = blend[39:16];
      above    = envelope > settings.onset_threshold;
      if (guard_left != '0) begin
         guard_left = guard_left - 1'b1;
      end else if (above && !was_above) begin
         if (slice_is_open) begin
            res.slice_start  = open_start;
            res.slice_end    = {1'b0, frame_count};
            res.slice_valid  = 1'b1;
            res.last_result  = 1'b0;
            res.total_slices = '0;
            expected_slices  = {expected_slices, res};
         end
         open_start    = frame_count;
         slice_is_open = 1'b1;
         if (slices_seen != '1) slices_seen = slices_seen + 1'b1;
         guard_left = settings.guard_length;
      end
      was_above = above;
      if (final_mark) begin
         res.slice_start  = slice_is_open ? open_start : '0;
         res.slice_end    = slice_is_open ? ({1'b0, frame_count} + 1'b1) : '0;
         res.slice_valid  = slice_is_open;
         res.last_result  = 1'b1;
         res.total_slices = slices_seen;
         expected_slices  = {expected_slices, res};
         clear_buffer_state();
      end else if (frame_count != '1) begin
         frame_count = frame_count + 1'b1;
      end
   endtask

   task automatic compare_result(input result_type want, input result_type got);
      if (got.slice_start !== want.slice_start)
         report_failure($sformatf("slice_start: expected %0d, got %0d",
                                  want.slice_start, got.slice_start));
      if (got.slice_end !== want.slice_end)
         report_failure($sformatf("slice_end: expected %0d, got %0d",
                                  want.slice_end, got.slice_end));
      if (got.slice_valid !== want.slice_valid)
         report_failure($sformatf("slice_valid: expected %0d, got %0d",
                                  want.slice_valid, got.slice_valid));
      if (got.last_result !== want.last_result)
         report_failure($sformatf("last_result: expected %0d, got %0d",
                                  want.last_result, got.last_result));
      if (got.total_slices !== want.total_slices)
         report_failure($sformatf("total_slices: expected %0d, got %0d",
                                  want.total_slices, got.total_slices));
   endtask

   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         settings.attack_coeff    = ATTACK_RESET;
         settings.release_coeff   = RELEASE_RESET;
         settings.guard_length    = GUARD_RESET;
         settings.onset_threshold = THRESHOLD_RESET;
         settings.channel_count   = CHANNELS_RESET;
         clear_buffer_state();
         expected_slices.delete();
         mismatch_count = 0;
      end else begin
         // A result can never stem from the frame accepted at the same edge, so compare first.
         if (rsp_tvalid && rsp_tready) begin
            got.slice_start  = rsp_tdata[23:0];
            got.slice_end    = rsp_tdata[48:24];
            got.total_slices = rsp_tdata[73:49];
            got.slice_valid  = rsp_tuser;
            got.last_result  = rsp_tlast;
            if (rsp_tdata[79:74] !== '0)
               report_failure($sformatf("tdata padding not zero: %0h", rsp_tdata[79:74]));
            if (expected_slices.size() == 0) begin
               report_failure($sformatf("result with none expected: start %0d end %0d last %0d",
                                        got.slice_start, got.slice_end, got.last_result));
            end else begin
               compare_result(expected_slices.pop_front(), got);
            end
         end
         if (req_tvalid && req_tready)
            predict_frame(req_tdata[23:0], req_tdata[47:24], req_tlast);
         if (csr_we) begin
            case (csr_index)
               CSR_ATTACK: begin
                  settings.attack_coeff = csr_wdata[COEFF_W-1:0];
               end
               CSR_RELEASE: begin
                  settings.release_coeff = csr_wdata[COEFF_W-1:0];
               end
               CSR_GUARD: begin
                  settings.guard_length = csr_wdata[GUARD_W-1:0];
               end
               CSR_THRESHOLD: begin
                  settings.onset_threshold = csr_wdata[THRESH_W-1:0];
               end
               CSR_CHANNELS: begin
                  settings.channel_count = csr_wdata[CHAN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending_results = expected_slices.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Top of the envelope onset slicer testbench: clock, reset, frame stimulus and the verdict.
module testbench;
   import eos_pkg::*;

   // Sample codes used when building frames.
   localparam int QUIET_SAMPLE = 0;
   localparam int LOUD_SAMPLE  = 1;
   localparam int NOISE_SAMPLE = 2;

   // Number of random frames to send after the directed part.
   localparam int RANDOM_FRAMES = 1500;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [23:0] left_sample, [47:24] right_sample
   logic                   req_tlast;   // final_frame
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // [23:0] slice_start, [48:24] slice_end,
                                        // [73:49] total_slices, [79:74] zero
   logic                   rsp_tuser;   // slice_valid
   logic                   rsp_tlast;   // last_result
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int pending_results;

   // When set, neither the frame source nor the result sink inserts any idle cycles.
   bit steady_flow;
   int frames_sent;

   envelope_onset_slicer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // The checker watches all three ports, so it sees exactly what the block accepted.
   eos_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The 20 ms timeout leaves a wide margin over the slowest correct run.
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Length of one idle stretch: usually short, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Result sink: stalls start at random and last for an idle_length() stretch.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 12) stall_left = idle_length();
         end
      end
   end

   // Builds one sample. Quiet and loud samples get a random sign; noise is any 24-bit value.
   function automatic logic [SAMPLE_W-1:0] make_sample(input int kind);
      logic [SAMPLE_W-1:0] mag;
      if (kind == NOISE_SAMPLE) return SAMPLE_W'($urandom);
      if (kind == LOUD_SAMPLE) begin
         mag = SAMPLE_W'($urandom_range(24'h300000, 24'h800000));
      end else begin
         mag = SAMPLE_W'($urandom_range(0, 24'h03FFFF));
      end
      return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
   endfunction

   // Presents one frame after an optional gap and returns on the falling edge after its
   // handshake. tvalid stays high on return, so the next frame follows without a bubble
   // unless the caller or the next frame's own gap drops it.
   task automatic send_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                             input logic final_mark);
      int gap;
      gap = (steady_flow || $urandom_range(0, 99) < 60) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {right, left};
      req_tlast  = final_mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      frames_sent++;
   endtask

   // Registers change only when the block is idle. Frames that cause no result may still sit
   // in the four-entry queue after the last result has left, so a short pause follows the
   // drain before any write.
   task automatic apply_settings(input int attack, input int release_factor, input int guard,
                                 input int threshold, input int channels);
      req_tvalid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_ATTACK;
      csr_wdata = CSR_DATA_W'(attack);
      @(negedge clock);
      csr_index = CSR_RELEASE;
      csr_wdata = CSR_DATA_W'(release_factor);
      @(negedge clock);
      csr_index = CSR_GUARD;
      csr_wdata = CSR_DATA_W'(guard);
      @(negedge clock);
      csr_index = CSR_THRESHOLD;
      csr_wdata = CSR_DATA_W'(threshold);
      @(negedge clock);
      csr_index = CSR_CHANNELS;
      csr_wdata = CSR_DATA_W'(channels);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // One buffer of audio ends with its final frame. Well-formed buffers alternate loud bursts
   // and quiet stretches so the envelope crosses the threshold again and again; noisy buffers
   // feed arbitrary samples. A stray noise frame also lands inside ordinary buffers.
   task automatic send_buffer(input int length, input bit noisy);
      int  run_left;
      int  kind;
      bit  loud;
      loud     = $urandom_range(0, 1);
      run_left = 0;
      for (int n = 0; n < length; n++) begin
         if (run_left == 0) begin
            loud     = !loud;
            run_left = loud ? $urandom_range(1, 8) : $urandom_range(1, 12);
         end
         if (noisy || $urandom_range(0, 19) == 0) kind = NOISE_SAMPLE;
         else kind = loud ? LOUD_SAMPLE : QUIET_SAMPLE;
         send_frame(make_sample(kind), make_sample(kind), n == length - 1);
         run_left--;
      end
   endtask

   initial begin
      int phase;
      int phase_target;
      int random_start;
      steady_flow = 1'b0;
      frames_sent = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_ATTACK;
      csr_wdata   = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset settings: a full-scale stereo burst (most negative left, most positive right)
      // lifts the envelope over the threshold within a few frames, and the final frame closes
      // the open slice. A lone silent final frame then closes a buffer with no slice at all.
      for (int n = 0; n < 8; n++) send_frame(24'h800000, 24'h7FFFFF, n == 7);
      send_frame(24'h000000, 24'h000000, 1'b1);

      // Instant attack and release in mono: every loud frame after a silent one is an onset.
      // The right channel is ignored, and the last frame carries both an onset result and
      // the closing result.
      apply_settings(0, 0, 0, 24'h400000, 1);
      send_frame(24'h7FFFFF, 24'h000000, 1'b0);
      send_frame(24'h000000, 24'h800000, 1'b0);
      send_frame(24'h800000, 24'h000000, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h800000, 24'h7FFFFF, 1'b1);

      // Channel count 3 behaves as stereo. An average exactly at the threshold is not above
      // it, one step more is. A two-frame guard hides the next rising crossing.
      apply_settings(0, 0, 2, 24'h400000, 3);
      send_frame(24'h000000, 24'h800000, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h000003, 24'h800000, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h800000, 24'h800000, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h7FFFFF, 24'h800001, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b1);

      // Random phases. The first three pin the register extremes: slowest coefficients with
      // the longest guard and a zero threshold, a threshold the envelope can only equal, and
      // one beyond full scale with mono selected by a zero channel count.
      random_start = frames_sent;
      phase        = 0;
      while (frames_sent - random_start < RANDOM_FRAMES) begin
         case (phase)
            0: begin
               apply_settings(65535, 65535, 65535, 0, 2);
            end
            1: begin
               apply_settings(0, 65535, 0, 24'h800000, 3);
            end
            2: begin
               apply_settings(40000, 0, 1, 24'hFFFFFF, 0);
            end
            default: begin
               apply_settings($urandom_range(0, 52000),
                              $urandom_range(0, 1) ? $urandom_range(40000, 65535)
                                                   : $urandom_range(0, 65535),
                              $urandom_range(0, 12),
                              $urandom_range(24'h080000, 24'h500000),
                              $urandom_range(0, 3));
            end
         endcase
         steady_flow  = ($urandom_range(0, 3) == 0);
         phase_target = frames_sent + $urandom_range(100, 180);
         while (frames_sent < phase_target) begin
            send_buffer($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 40),
                        $urandom_range(0, 9) == 0);
         end
         phase++;
      end

      // Let every expected result arrive, then give the block time to show anything extra.
      req_tvalid  = 1'b0;
      steady_flow = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
